>>> hw/rtl/baro_pressure_temp_compensation_assert.svh
// Assertion macros for the barometric compensation block.
// Depends on nothing; included by the top level only.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define BPTC_ASSERT_IMP(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("bptc assertion failed");
// next-cycle implication
`define BPTC_ASSERT_NXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("bptc assertion failed");
`else
`define BPTC_ASSERT_IMP(lbl, ck, rn, a, c)
`define BPTC_ASSERT_NXT(lbl, ck, rn, a, c)
`endif
`endif

>>> hw/rtl/bptc_pkg.sv
// Types and constants shared by the barometric compensation pipeline.
// No dependencies.
package bptc_pkg;

	localparam int RAW_W  = 24;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;
	localparam int DT_W   = 25;
	localparam int TEMP_W = 20;
	localparam int T2_W   = 19;
	localparam int CORR_W = 42;   // offset / sensitivity accumulators
	localparam int SQ_W   = 40;

	localparam logic [IDX_W-1:0] REG_SENS       = 3'd0;
	localparam logic [IDX_W-1:0] REG_OFFSET     = 3'd1;
	localparam logic [IDX_W-1:0] REG_SENS_TEMP  = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFFSET_TEMP = 3'd3;
	localparam logic [IDX_W-1:0] REG_REF_TEMP   = 3'd4;
	localparam logic [IDX_W-1:0] REG_TEMP_SLOPE = 3'd5;

	// 20.00 C and -15.00 C thresholds, in 0.01 C
	localparam logic signed [TEMP_W-1:0] TEMP_REF   = 20'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_VCOLD = -20'sd1500;

	typedef struct packed {
		logic [RAW_W-1:0] pressure_raw;
		logic [RAW_W-1:0] temp_raw;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] temperature;
		logic signed [31:0] pressure;
	} out_beat_t;

	typedef struct packed {
		logic [CFG_W-1:0] sens_coeff;
		logic [CFG_W-1:0] offset_coeff;
		logic [CFG_W-1:0] sens_temp_coeff;
		logic [CFG_W-1:0] offset_temp_coeff;
		logic [CFG_W-1:0] ref_temp_coeff;
		logic [CFG_W-1:0] temp_slope_coeff;
	} cfg_t;

	// first-order results
	typedef struct packed {
		logic [RAW_W-1:0]         p;
		logic signed [TEMP_W-1:0] temp;
		logic [T2_W-1:0]          t2;
		logic signed [CORR_W-1:0] off1;
		logic signed [CORR_W-1:0] sens1;
		logic signed [TEMP_W-1:0] d;     // temp - 20.00 C
		logic signed [TEMP_W-1:0] e;     // temp + 15.00 C
		logic                     cold;
		logic                     vcold;
	} front_t;

	// corrected terms
	typedef struct packed {
		logic [RAW_W-1:0]         p;
		logic signed [31:0]       temperature;
		logic signed [CORR_W-1:0] off;
		logic signed [CORR_W-1:0] sens;
	} corr_t;

endpackage

>>> hw/rtl/bptc_front.sv
// Stages 1-3: temperature difference, three coefficient products and dT squared,
// first-order temperature, offset and sensitivity. Uses bptc_pkg.
module bptc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld,
	input  bptc_pkg::in_beat_t beat,
	input  bptc_pkg::cfg_t    cfg,
	output logic              vld_out,
	output bptc_pkg::front_t  res
);

	// stage 1
	logic                                vld_s1;
	logic [bptc_pkg::RAW_W-1:0]          p_s1;
	logic signed [bptc_pkg::DT_W-1:0]    dt_s1;
	logic signed [bptc_pkg::DT_W-1:0]    dt_c;

	assign dt_c = $signed({1'b0, beat.temp_raw})
		- $signed({1'b0, cfg.ref_temp_coeff, 8'h00});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= beat.pressure_raw;
			dt_s1 <= dt_c;
		end
	end

	// stage 2: products
	logic                       vld_s2;
	logic [bptc_pkg::RAW_W-1:0] p_s2;
	logic signed [41:0]         tprod_s2, oprod_s2, sprod_s2;
	logic signed [49:0]         dtsq_s2;
	logic signed [16:0]         slope_c, offtc_c, senstc_c;

	assign slope_c  = $signed({1'b0, cfg.temp_slope_coeff});
	assign offtc_c  = $signed({1'b0, cfg.offset_temp_coeff});
	assign senstc_c = $signed({1'b0, cfg.sens_temp_coeff});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2     <= p_s1;
			tprod_s2 <= dt_s1 * slope_c;
			oprod_s2 <= dt_s1 * offtc_c;
			sprod_s2 <= dt_s1 * senstc_c;
			dtsq_s2  <= dt_s1 * dt_s1;
		end
	end

	// stage 3: first-order terms. temp - 2000 is just the shifted product.
	logic               vld_s3;
	bptc_pkg::front_t   res_s3;
	bptc_pkg::front_t   res_c;
	logic signed [18:0] tsh_c;

	assign tsh_c = tprod_s2[41:23];

	always_comb begin
		res_c.p     = p_s2;
		res_c.d     = {tsh_c[18], tsh_c};
		res_c.temp  = res_c.d + bptc_pkg::TEMP_REF;
		res_c.e     = res_c.d + (bptc_pkg::TEMP_REF - bptc_pkg::TEMP_VCOLD);
		// dT^2 term applies only below 20.00 C
		res_c.t2    = tsh_c[18] ? dtsq_s2[49:31] : '0;
		res_c.cold  = tsh_c[18];
		res_c.vcold = res_c.e[bptc_pkg::TEMP_W-1];
		res_c.off1  = $signed({10'b0, cfg.offset_coeff, 16'h0000})
			+ {{7{oprod_s2[41]}}, oprod_s2[41:7]};
		res_c.sens1 = $signed({11'b0, cfg.sens_coeff, 15'h0000})
			+ {{8{sprod_s2[41]}}, sprod_s2[41:8]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_c;
		end
	end

	assign vld_out = vld_s3;
	assign res     = res_s3;

endmodule

>>> hw/rtl/bptc_corr.sv
// Stages 4-5: second-order squares and the cold / very cold corrections.
// Uses bptc_pkg.
module bptc_corr (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld,
	input  bptc_pkg::front_t fr,
	output logic             vld_out,
	output bptc_pkg::corr_t  res
);

	// stage 4: squares
	logic                              vld_s4;
	bptc_pkg::front_t                  fr_s4;
	logic signed [bptc_pkg::SQ_W-1:0]  dsq_s4, esq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s4  <= fr;
			dsq_s4 <= fr.d * fr.d;
			esq_s4 <= fr.e * fr.e;
		end
	end

	// stage 5: squares are non-negative, so plain shifts floor them
	logic [bptc_pkg::CORR_W-1:0] dsq_w, esq_w, five_d, seven_e, eleven_e;
	logic [bptc_pkg::CORR_W-1:0] off2_c, sens2_c;
	bptc_pkg::corr_t             res_c;
	logic                        vld_s5;
	bptc_pkg::corr_t             res_s5;

	always_comb begin
		dsq_w    = bptc_pkg::CORR_W'(unsigned'(dsq_s4));
		esq_w    = bptc_pkg::CORR_W'(unsigned'(esq_s4));
		five_d   = (dsq_w << 2) + dsq_w;
		seven_e  = (esq_w << 3) - esq_w;
		eleven_e = (esq_w << 3) + (esq_w << 1) + esq_w;
		off2_c   = '0;
		sens2_c  = '0;
		if (fr_s4.cold) begin
			off2_c  = five_d >> 1;
			sens2_c = five_d >> 2;
		end
		if (fr_s4.vcold) begin
			off2_c  = off2_c + seven_e;
			sens2_c = sens2_c + (eleven_e >> 1);
		end
		res_c.p           = fr_s4.p;
		res_c.off         = fr_s4.off1 - $signed(off2_c);
		res_c.sens        = fr_s4.sens1 - $signed(sens2_c);
		res_c.temperature = {{(32-bptc_pkg::TEMP_W){fr_s4.temp[bptc_pkg::TEMP_W-1]}},
			fr_s4.temp} - $signed({{(32-bptc_pkg::T2_W){1'b0}}, fr_s4.t2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5 <= res_c;
		end
	end

	assign vld_out = vld_s5;
	assign res     = res_s5;

endmodule

>>> hw/rtl/bptc_pres.sv
// Stages 6-7: pressure product split into two partial products, then the
// offset subtract and final shift. Uses bptc_pkg.
module bptc_pres (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld,
	input  bptc_pkg::corr_t     cr,
	output logic                vld_out,
	output bptc_pkg::out_beat_t beat
);

	// stage 6: sens = hi * 2^21 + lo
	logic                              vld_s6;
	logic signed [45:0]                hi_s6;
	logic [44:0]                       lo_s6;
	logic signed [bptc_pkg::CORR_W-1:0] off_s6;
	logic signed [31:0]                temp_s6;
	logic signed [20:0]                sh_c;
	logic signed [24:0]                p_c;

	assign sh_c = cr.sens[41:21];
	assign p_c  = $signed({1'b0, cr.p});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s6   <= p_c * sh_c;
			lo_s6   <= cr.p * cr.sens[20:0];
			off_s6  <= cr.off;
			temp_s6 <= cr.temperature;
		end
	end

	// stage 7: floor(p*sens / 2^21) = hi + floor(lo / 2^21)
	logic signed [47:0]  q_c;
	logic                vld_s7;
	bptc_pkg::out_beat_t beat_s7;

	assign q_c = {{2{hi_s6[45]}}, hi_s6} + $signed({24'b0, lo_s6[44:21]})
		- {{(48-bptc_pkg::CORR_W){off_s6[bptc_pkg::CORR_W-1]}}, off_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beat_s7.temperature <= temp_s6;
			beat_s7.pressure    <= q_c[46:15];
		end
	end

	assign vld_out = vld_s7;
	assign beat    = beat_s7;

endmodule

>>> hw/rtl/baro_pressure_temp_compensation.sv
// Barometric sensor compensation with second-order temperature correction.
// Input channel: in_valid / in_stall carry one raw pressure / temperature
// pair per beat in in_data. Output channel: out_valid / out_stall carry
// the compensated temperature (0.01 C) and pressure (Pa) in out_data.
// Six 16-bit calibration words are written through wr_en / wr_idx /
// wr_data; write them only while no beat is in flight. Indexes past the
// last register are dropped.
// An accepted beat passes the stage registers 1 to 7 in order and is then
// shown on out_valid, from stage 7 or from the skid entry.
// Throughput is one beat per cycle while nothing stalls, set by the
// seven-stage pipeline (one wide multiply layer per stage at most).
// Reset clears all pipeline valid bits, the skid valid bit and the calibration
// words to zero.
// When out_stall is held, the beat on the output moves into a one-entry
// skid register; from the next cycle in_stall is high and the pipeline
// holds. in_stall comes from that register only, so no path runs from
// out_stall to in_stall. Depends on bptc_pkg, bptc_front, bptc_corr,
// bptc_pres and the assertion header.
`include "baro_pressure_temp_compensation_assert.svh"

module baro_pressure_temp_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bptc_pkg::in_beat_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bptc_pkg::out_beat_t           out_data,
	input  logic                          wr_en,
	input  logic [bptc_pkg::IDX_W-1:0]    wr_idx,
	input  logic [bptc_pkg::CFG_W-1:0]    wr_data
);

	// calibration registers
	bptc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				bptc_pkg::REG_SENS:        cfg_q.sens_coeff        <= wr_data;
				bptc_pkg::REG_OFFSET:      cfg_q.offset_coeff      <= wr_data;
				bptc_pkg::REG_SENS_TEMP:   cfg_q.sens_temp_coeff   <= wr_data;
				bptc_pkg::REG_OFFSET_TEMP: cfg_q.offset_temp_coeff <= wr_data;
				bptc_pkg::REG_REF_TEMP:    cfg_q.ref_temp_coeff    <= wr_data;
				bptc_pkg::REG_TEMP_SLOPE:  cfg_q.temp_slope_coeff  <= wr_data;
				default: begin
					// out-of-range index: no register
				end
			endcase
		end
	end

	// pipeline advances whenever the skid entry is empty
	logic                en;
	logic                skid_vld_q;
	bptc_pkg::out_beat_t skid_q;

	assign en       = !skid_vld_q;
	assign in_stall = skid_vld_q;

	// stages 1-3
	logic             vld_fr;
	bptc_pkg::front_t fr;

	bptc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (in_valid),
		.beat    (in_data),
		.cfg     (cfg_q),
		.vld_out (vld_fr),
		.res     (fr)
	);

	// stages 4-5
	logic            vld_cr;
	bptc_pkg::corr_t cr;

	bptc_corr u_corr (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (vld_fr),
		.fr      (fr),
		.vld_out (vld_cr),
		.res     (cr)
	);

	// stages 6-7
	logic                vld_s7;
	bptc_pkg::out_beat_t beat_s7;

	bptc_pres u_pres (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (vld_cr),
		.cr      (cr),
		.vld_out (vld_s7),
		.beat    (beat_s7)
	);

	// skid: park the stage-7 beat when the receiver stalls it
	logic skid_load;

	assign skid_load = en && vld_s7 && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_load) begin
			skid_vld_q <= 1'b1;
		end else if (skid_vld_q && !out_stall) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_load) begin
			skid_q <= beat_s7;
		end
	end

	// the skid beat is older than whatever waits in stage 7
	assign out_valid = skid_vld_q || vld_s7;
	assign out_data  = skid_vld_q ? skid_q : beat_s7;

	`BPTC_ASSERT_NXT(a_skid_catch, clk, arst_n, vld_s7 && out_stall && !skid_vld_q, skid_vld_q)
	`BPTC_ASSERT_NXT(a_skid_drain, clk, arst_n, skid_vld_q && !out_stall, !skid_vld_q)
	`BPTC_ASSERT_NXT(a_skid_freeze, clk, arst_n, skid_vld_q, vld_s7 == $past(vld_s7))

endmodule
